@@ design/spt_pkg.sv @@
`default_nettype none

package spt_pkg;

  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned DefCoordWidth = 32;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned PortCoordW = 32;
  localparam int unsigned ReadIdxW  = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned TolW      = 16;

  localparam logic [TolW-1:0] TolReset = 16'd7;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_DUP_MISS = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_FIN
  } state_e;

  // per-cell update command
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // per-cell compare result against the broadcast point
  typedef struct packed {
    logic place;
    logic dup;
    logic match;
  } cell_hit_t;

endpackage

`default_nettype wire

@@ design/spt_cell.sv @@
`default_nettype none

module spt_cell #(
  parameter int unsigned CoordWidth = spt_pkg::DefCoordWidth
) (
  input  wire logic                    clk_i,
  input  wire spt_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [spt_pkg::TolW-1:0] tol_i,
  input  wire logic [CoordWidth-1:0]   new_x_i,
  input  wire logic [CoordWidth-1:0]   new_y_i,
  input  wire logic [CoordWidth-1:0]   new_z_i,
  input  wire logic [CoordWidth-1:0]   prev_x_i,
  input  wire logic [CoordWidth-1:0]   prev_y_i,
  input  wire logic [CoordWidth-1:0]   prev_z_i,
  output logic      [CoordWidth-1:0]   x_o,
  output logic      [CoordWidth-1:0]   y_o,
  output logic      [CoordWidth-1:0]   z_o,
  output spt_pkg::cell_hit_t           hit_o
);

  localparam int unsigned DiffW = CoordWidth + spt_pkg::TolW + 2;

  logic [CoordWidth-1:0] x_q, y_q, z_q;
  logic signed [DiffW-1:0] dx, dy, tol_pos, tol_neg;
  logic x_win, y_win, lt_x, lt_y;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= new_x_i;
      y_q <= new_y_i;
      z_q <= new_z_i;
    end else if (ctrl_i.shift) begin
      x_q <= prev_x_i;
      y_q <= prev_y_i;
      z_q <= prev_z_i;
    end
  end

  always_comb begin
    dx = $signed({{(DiffW-CoordWidth){new_x_i[CoordWidth-1]}}, new_x_i})
       - $signed({{(DiffW-CoordWidth){x_q[CoordWidth-1]}}, x_q});
    dy = $signed({{(DiffW-CoordWidth){new_y_i[CoordWidth-1]}}, new_y_i})
       - $signed({{(DiffW-CoordWidth){y_q[CoordWidth-1]}}, y_q});
    tol_pos = $signed({{(DiffW-spt_pkg::TolW){1'b0}}, tol_i});
    tol_neg = -tol_pos;
    x_win = (dx > tol_neg) && (dx <= tol_pos);
    y_win = (dy > tol_neg) && (dy <= tol_pos);
    lt_x  = $signed(new_x_i) < $signed(x_q);
    lt_y  = $signed(new_y_i) < $signed(y_q);
    hit_o.place = lt_x | (x_win & lt_y);
    hit_o.dup   = ~hit_o.place & x_win & y_win;
    hit_o.match = x_win & y_win;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

@@ design/spt_prefix.sv @@
`default_nettype none

// prefix OR over the cell row, one doubling distance per cycle
module spt_prefix #(
  parameter int unsigned TableDepth = spt_pkg::DefTableDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [TableDepth-1:0] seed_i,
  output logic                       done_o,
  output logic      [TableDepth-1:0] pre_o
);

  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned StepW = (IdxW > 1) ? $clog2(IdxW) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(IdxW - 1);

  logic [TableDepth-1:0] pre_q, pre_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  run_q, run_d;
  logic [IdxW:0]         shamt;

  always_comb begin
    shamt  = (IdxW+1)'(1) << step_q;
    done_o = run_q && (step_q == LastStep);
    pre_d  = pre_q;
    step_d = step_q;
    run_d  = run_q;
    if (start_i) begin
      pre_d  = seed_i;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      pre_d  = pre_q | (pre_q << shamt);
      step_d = step_q + StepW'(1);
      run_d  = !done_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  assign pre_o = pre_q;

endmodule

`default_nettype wire

@@ design/sorted_point_table_tolerance.sv @@
// Sorted point table with tolerance-based duplicate removal.
// Input channel: in_valid_i / in_stall_o with mode, x, y, z and read index.
// An item is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i, one result per item, held
// stable while out_stall_i is high.
// Config channel: cfg_valid_i / cfg_ready_o writes the match tolerance;
// cfg_ready_o is always high, write only while no item is in flight.
// Points live in a row of cells, one entry each; an insert shifts the
// tail of the row by one cell at once, at the commit.
// Steps: compare in all cells (S_CMP), first-hit search by prefix OR
// (S_SCAN), commit (S_FIN). One item is handled at a time, so a new
// item is taken only after the last one has committed. A stalled output
// holds the commit cycle until free.
// Reset empties the table and sets the tolerance to 7.
`default_nettype none

module sorted_point_table_tolerance #(
  parameter int unsigned TABLE_DEPTH = spt_pkg::DefTableDepth,
  parameter int unsigned COORD_WIDTH = spt_pkg::DefCoordWidth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [spt_pkg::TolW-1:0]         cfg_tolerance_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [spt_pkg::ModeW-1:0]        mode_i,
  input  wire logic signed [spt_pkg::PortCoordW-1:0] x_coord_i,
  input  wire logic signed [spt_pkg::PortCoordW-1:0] y_coord_i,
  input  wire logic signed [spt_pkg::PortCoordW-1:0] z_coord_i,
  input  wire logic [spt_pkg::ReadIdxW-1:0]     read_index_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [spt_pkg::CountW-1:0]            point_count_o,
  output logic [spt_pkg::CountW-1:0]            match_index_o,
  output logic [spt_pkg::StatusW-1:0]           status_o,
  output logic signed [spt_pkg::PortCoordW-1:0] out_x_o,
  output logic signed [spt_pkg::PortCoordW-1:0] out_y_o,
  output logic signed [spt_pkg::PortCoordW-1:0] out_z_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned PW    = spt_pkg::PortCoordW;
  localparam int unsigned OW    = spt_pkg::CountW;
  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RiW   = spt_pkg::ReadIdxW;
  localparam int unsigned CmpW  = (CntW > RiW) ? CntW : RiW;
  localparam logic [CntW-1:0] FullCount = CntW'(TABLE_DEPTH);

  spt_pkg::state_e state_q, state_d;
  spt_pkg::mode_e  mode_q;

  logic [CW-1:0]   bx_q, by_q, bz_q;
  logic [RiW-1:0]  ridx_q;
  logic [spt_pkg::TolW-1:0] tol_q;
  logic [CntW-1:0] count_q, count_d;

  logic in_fire, start_scan, commit;

  logic [CW-1:0] cx [TABLE_DEPTH];
  logic [CW-1:0] cy [TABLE_DEPTH];
  logic [CW-1:0] cz [TABLE_DEPTH];
  spt_pkg::cell_hit_t  hit  [TABLE_DEPTH];
  spt_pkg::cell_ctrl_t ctrl [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] seed, dupv, dup_q, pre, pprev, first, at_cnt;
  logic                   scan_done;

  logic                out_valid_q;
  logic [OW-1:0]       count_o_q, match_o_q, count_o_d, match_o_d;
  spt_pkg::status_e    status_q, status_d;
  logic [PW-1:0]       ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;

  logic [CW+PW-1:0] ext_x, ext_y, ext_z;
  logic             found, dup_hit, full, ins_ok, app_ok;
  logic [IdxW-1:0]  enc;
  logic [CW-1:0]    rd_x, rd_y, rd_z;
  logic [CmpW-1:0]  ridx_w, cnt_w, ksel;

  // input coordinates to table width
  assign ext_x = {{CW{x_coord_i[PW-1]}}, x_coord_i};
  assign ext_y = {{CW{y_coord_i[PW-1]}}, y_coord_i};
  assign ext_z = {{CW{z_coord_i[PW-1]}}, z_coord_i};

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != spt_pkg::S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    start_scan = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      spt_pkg::S_IDLE: begin
        if (in_fire) state_d = spt_pkg::S_CMP;
      end
      spt_pkg::S_CMP: begin
        start_scan = 1'b1;
        state_d    = spt_pkg::S_SCAN;
      end
      spt_pkg::S_SCAN: begin
        if (scan_done) state_d = spt_pkg::S_FIN;
      end
      spt_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = spt_pkg::S_IDLE;
        end
      end
      default: state_d = spt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= spt_pkg::TolReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= spt_pkg::mode_e'(mode_i);
      bx_q   <= ext_x[CW-1:0];
      by_q   <= ext_y[CW-1:0];
      bz_q   <= ext_z[CW-1:0];
      ridx_q <= read_index_i;
    end
    if (start_scan) dup_q <= dupv;
  end

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spt_cell #(.CoordWidth(CW)) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl[i]),
        .tol_i   (tol_q),
        .new_x_i (bx_q),
        .new_y_i (by_q),
        .new_z_i (bz_q),
        .prev_x_i(bx_q),
        .prev_y_i(by_q),
        .prev_z_i(bz_q),
        .x_o     (cx[i]),
        .y_o     (cy[i]),
        .z_o     (cz[i]),
        .hit_o   (hit[i])
      );
    end else begin : g_body
      spt_cell #(.CoordWidth(CW)) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl[i]),
        .tol_i   (tol_q),
        .new_x_i (bx_q),
        .new_y_i (by_q),
        .new_z_i (bz_q),
        .prev_x_i(cx[i-1]),
        .prev_y_i(cy[i-1]),
        .prev_z_i(cz[i-1]),
        .x_o     (cx[i]),
        .y_o     (cy[i]),
        .z_o     (cz[i]),
        .hit_o   (hit[i])
      );
    end
  end

  // read index clamp
  assign ridx_w = CmpW'(ridx_q);
  assign cnt_w  = CmpW'(count_q);
  assign ksel   = (ridx_w < cnt_w) ? ridx_w : (cnt_w - CmpW'(1));

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_seed
    logic occ;
    assign occ       = CntW'(i) < count_q;
    assign at_cnt[i] = count_q == CntW'(i);
    assign dupv[i]   = occ & hit[i].dup;
    always_comb begin
      unique case (mode_q)
        spt_pkg::MODE_INSERT: seed[i] = occ & (hit[i].place | hit[i].dup);
        spt_pkg::MODE_LOOKUP: seed[i] = occ & hit[i].match;
        spt_pkg::MODE_READ:   seed[i] = (count_q != '0) && (ksel == CmpW'(i));
        default:              seed[i] = 1'b0;
      endcase
    end
    assign pprev[i] = (i == 0) ? 1'b0 : pre[(i == 0) ? 0 : i - 1];
    assign first[i] = pre[i] & ~pprev[i];
    assign ctrl[i].load  = commit &
                           ((ins_ok & (found ? first[i] : at_cnt[i])) | (app_ok & at_cnt[i]));
    assign ctrl[i].shift = commit & ins_ok & pprev[i];
  end

  spt_prefix #(.TableDepth(TABLE_DEPTH)) u_prefix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_scan),
    .seed_i (seed),
    .done_o (scan_done),
    .pre_o  (pre)
  );

  // first-hit encode and entry select
  always_comb begin
    enc  = '0;
    rd_x = '0;
    rd_y = '0;
    rd_z = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first[i]) begin
        enc  = enc | IdxW'(i);
        rd_x = rd_x | cx[i];
        rd_y = rd_y | cy[i];
        rd_z = rd_z | cz[i];
      end
    end
  end

  assign found   = pre[TABLE_DEPTH-1];
  assign dup_hit = |(first & dup_q);
  assign full    = count_q == FullCount;
  assign ins_ok  = (mode_q == spt_pkg::MODE_INSERT) && !full && !dup_hit;
  assign app_ok  = (mode_q == spt_pkg::MODE_APPEND) && !full;

  always_comb begin
    logic [CntW+OW-1:0] wide_cnt, wide_match;
    logic [CW+PW-1:0]   wx, wy, wz;
    count_d = count_q;
    if (ins_ok || app_ok) count_d = count_q + CntW'(1);
    wide_cnt   = {{OW{1'b0}}, count_d};
    wide_match = {{OW{1'b0}}, found ? CntW'(enc) : count_q};
    wx = {{PW{1'b0}}, rd_x};
    wy = {{PW{1'b0}}, rd_y};
    wz = {{PW{1'b0}}, rd_z};
    count_o_d = wide_cnt[OW-1:0];
    match_o_d = '0;
    ox_d      = '0;
    oy_d      = '0;
    oz_d      = '0;
    unique case (mode_q)
      spt_pkg::MODE_INSERT: begin
        priority if (full)    status_d = spt_pkg::ST_FULL;
        else if (dup_hit)     status_d = spt_pkg::ST_DUP_MISS;
        else                  status_d = spt_pkg::ST_OK;
      end
      spt_pkg::MODE_APPEND: begin
        status_d = full ? spt_pkg::ST_FULL : spt_pkg::ST_OK;
      end
      spt_pkg::MODE_LOOKUP: begin
        status_d  = found ? spt_pkg::ST_OK : spt_pkg::ST_DUP_MISS;
        match_o_d = wide_match[OW-1:0];
      end
      default: begin
        status_d = (count_q == '0) ? spt_pkg::ST_EMPTY : spt_pkg::ST_OK;
        ox_d     = wx[PW-1:0];
        oy_d     = wy[PW-1:0];
        oz_d     = wz[PW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      count_o_q <= count_o_d;
      match_o_q <= match_o_d;
      status_q  <= status_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      oz_q      <= oz_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_count_o = count_o_q;
  assign match_index_o = match_o_q;
  assign status_o      = status_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_z_o       = oz_q;

endmodule

`default_nettype wire
